/* rtl/core/rdv_pkg.sv */
// ----------------------------------------------------------------------------
// Rotor downwash velocity package
// Shared types, register codes and pipeline constants.
// ----------------------------------------------------------------------------
package rdv_pkg;

  typedef enum logic [2:0] {
    REG_ROTOR_X      = 3'd0,
    REG_ROTOR_Y      = 3'd1,
    REG_ROTOR_Z      = 3'd2,
    REG_DIRECTION    = 3'd3,
    REG_RADIUS       = 3'd4,
    REG_FORCE        = 3'd5,
    REG_FADE_START_Z = 3'd6,
    REG_FADE_SPAN    = 3'd7
  } cfg_idx_e;

  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 48;

  // Divider: DIV_QW quotient bits, numerator must stay below den * 2^DIV_QW.
  localparam int unsigned DIV_DW = 44;
  localparam int unsigned DIV_QW = 25;
  localparam int unsigned DIV_NW = DIV_DW + DIV_QW;

  localparam int unsigned SQ_IW = 62;
  localparam int unsigned SQ_OW = SQ_IW / 2;

  localparam logic [16:0] V_ONE    = 17'h10000;
  localparam logic [16:0] V_ZERO   = 17'h00000;
  localparam logic [24:0] V_UNIT_X = 25'h1000000;

  localparam int unsigned ST_OFF   = 1;
  localparam int unsigned ST_SQ    = 2;
  localparam int unsigned ST_SUM   = 3;
  localparam int unsigned ST_AFF   = 4;
  localparam int unsigned ST_PROD  = 5;
  localparam int unsigned ST_M1    = 6;
  localparam int unsigned ST_FADE  = ST_OFF + DIV_QW + 1;
  localparam int unsigned ST_ZPROD = ST_FADE + 1;
  localparam int unsigned ST_VZ    = ST_FADE + 2;
  localparam int unsigned ST_S     = ST_FADE + 3;
  localparam int unsigned ST_Q     = ST_AFF + DIV_QW + 1;
  localparam int unsigned ST_MQ    = ST_Q + 1;
  localparam int unsigned ST_M2    = ST_Q + 2;
  localparam int unsigned ST_N     = ST_S + SQ_OW + 1;
  localparam int unsigned ST_U     = ST_N + DIV_QW + 1;
  localparam int unsigned ST_MP    = ST_U + 1;
  localparam int unsigned ST_MR    = ST_U + 2;
  localparam int unsigned ST_VEL   = ST_U + 3;
  localparam int unsigned PIPE_DEPTH = ST_VEL;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               affected;
  } out_t;

  typedef struct packed {
    logic signed [24:0] ox;
    logic signed [24:0] oy;
    logic signed [24:0] oz;
    logic signed [24:0] h;
    logic [49:0]        sq_x;
    logic [49:0]        sq_y;
    logic [49:0]        sq_z;
    logic [40:0]        pd_x;
    logic [40:0]        pd_y;
    logic [40:0]        pd_z;
    logic [51:0]        d2;
    logic signed [42:0] dot;
    logic               aff;
    logic [43:0]        diff;
    logic               fade_ge;
    logic               fade_le;
    logic [53:0]        prod;
    logic [31:0]        m1;
    logic [16:0]        fade16;
    logic [39:0]        zprod;
    logic [30:0]        vz;
    logic [61:0]        vzsq;
    logic [61:0]        s;
    logic [16:0]        q;
    logic [48:0]        mq;
    logic [31:0]        m2;
    logic [30:0]        n;
    logic [24:0]        ux;
    logic [24:0]        uy;
    logic [24:0]        uz;
    logic [56:0]        mpx;
    logic [56:0]        mpy;
    logic [56:0]        mpz;
    logic [32:0]        mx;
    logic [32:0]        my;
    logic [32:0]        mz;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    out_t               vel;
  } pipe_t;

endpackage

/* rtl/core/rotor_downwash_velocity_top.sv */
// ----------------------------------------------------------------------------
// Rotor downwash velocity
// Downwash wind velocity of one rotor at a query point, fixed point.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle while the output buffer is not full; the pipeline length is set by the chain
//   of the fade divider, the square-root unit and the normalizing dividers.
// A two-entry output buffer keeps the pipeline running while out_stall_i is
//   high for one cycle; the input stalls only when that buffer is full.
// Reset clears the configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module rotor_downwash_velocity_top
  import rdv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  function automatic logic [24:0] mag25(logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  function automatic logic [31:0] sat32(logic [32:0] m, logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (m >= 33'h080000000) ? 32'h80000000 : 32'(-m[31:0]);
    end else begin
      r = (m > 33'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
    return r;
  endfunction

  logic signed [23:0] rotor_x_q, rotor_y_q, rotor_z_q, fade_start_q;
  logic [47:0]        dir_q;
  logic [21:0]        radius_q, span_q;
  logic [15:0]        force_q;
  logic [43:0]        r2_q;

  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [15:0]        force_mag;

  pipe_t pipe_q [1:PIPE_DEPTH];
  pipe_t pipe_d [1:PIPE_DEPTH];
  logic  vld_q  [1:PIPE_DEPTH];

  logic en;
  logic in_acc;

  logic [DIV_NW-1:0] fdiv_num, qdiv_num, udiv_num_x, udiv_num_y, udiv_num_z;
  logic [DIV_QW-1:0] fdiv_quo, qdiv_quo, udiv_quo_x, udiv_quo_y, udiv_quo_z;
  logic [SQ_OW-1:0]  sqrt_root;

  out_t out_q, out_d, skid_q, skid_d;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_x_q    <= '0;
      rotor_y_q    <= '0;
      rotor_z_q    <= '0;
      dir_q        <= '0;
      radius_q     <= '0;
      force_q      <= '0;
      fade_start_q <= '0;
      span_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_ROTOR_X:      rotor_x_q    <= cfg_data_i[23:0];
        REG_ROTOR_Y:      rotor_y_q    <= cfg_data_i[23:0];
        REG_ROTOR_Z:      rotor_z_q    <= cfg_data_i[23:0];
        REG_DIRECTION:    dir_q        <= cfg_data_i[47:0];
        REG_RADIUS:       radius_q     <= cfg_data_i[21:0];
        REG_FORCE:        force_q      <= cfg_data_i[15:0];
        REG_FADE_START_Z: fade_start_q <= cfg_data_i[23:0];
        REG_FADE_SPAN:    span_q       <= cfg_data_i[21:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= {22'b0, radius_q} * {22'b0, radius_q};
  end

  assign dir_x     = dir_q[15:0];
  assign dir_y     = dir_q[31:16];
  assign dir_z     = dir_q[47:32];
  assign force_mag = force_q[15] ? 16'(-force_q) : force_q;

  // Pipeline control
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;

  // Datapath
  always_comb begin
    logic [24:0] ax, ay, az;
    logic [30:0] vz_c;
    ax = mag25(pipe_q[ST_N].ox);
    ay = mag25(pipe_q[ST_N].oy);
    az = '0;
    vz_c = pipe_q[ST_ZPROD].zprod[38:8];

    pipe_d[1] = '0;
    for (int k = 2; k <= int'(PIPE_DEPTH); k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    pipe_d[ST_OFF].ox = {in_data_i.point_x[23], in_data_i.point_x} -
                        {rotor_x_q[23], rotor_x_q};
    pipe_d[ST_OFF].oy = {in_data_i.point_y[23], in_data_i.point_y} -
                        {rotor_y_q[23], rotor_y_q};
    pipe_d[ST_OFF].oz = {in_data_i.point_z[23], in_data_i.point_z} -
                        {rotor_z_q[23], rotor_z_q};
    pipe_d[ST_OFF].h  = {in_data_i.point_z[23], in_data_i.point_z} -
                        {fade_start_q[23], fade_start_q};

    az = mag25(pipe_q[ST_OFF].ox);
    pipe_d[ST_SQ].sq_x = {25'b0, az} * {25'b0, az};
    az = mag25(pipe_q[ST_OFF].oy);
    pipe_d[ST_SQ].sq_y = {25'b0, az} * {25'b0, az};
    az = mag25(pipe_q[ST_OFF].oz);
    pipe_d[ST_SQ].sq_z = {25'b0, az} * {25'b0, az};
    pipe_d[ST_SQ].pd_x = {{16{pipe_q[ST_OFF].ox[24]}}, pipe_q[ST_OFF].ox} *
                         {{25{dir_x[15]}}, dir_x};
    pipe_d[ST_SQ].pd_y = {{16{pipe_q[ST_OFF].oy[24]}}, pipe_q[ST_OFF].oy} *
                         {{25{dir_y[15]}}, dir_y};
    pipe_d[ST_SQ].pd_z = {{16{pipe_q[ST_OFF].oz[24]}}, pipe_q[ST_OFF].oz} *
                         {{25{dir_z[15]}}, dir_z};
    pipe_d[ST_SQ].fade_ge = pipe_q[ST_OFF].h >= $signed({3'b000, span_q});
    pipe_d[ST_SQ].fade_le = pipe_q[ST_OFF].h <= 25'sd0;

    pipe_d[ST_SUM].d2  = {2'b0, pipe_q[ST_SQ].sq_x} + {2'b0, pipe_q[ST_SQ].sq_y} +
                         {2'b0, pipe_q[ST_SQ].sq_z};
    pipe_d[ST_SUM].dot = $signed({{2{pipe_q[ST_SQ].pd_x[40]}}, pipe_q[ST_SQ].pd_x}) +
                         $signed({{2{pipe_q[ST_SQ].pd_y[40]}}, pipe_q[ST_SQ].pd_y}) +
                         $signed({{2{pipe_q[ST_SQ].pd_z[40]}}, pipe_q[ST_SQ].pd_z});

    pipe_d[ST_AFF].aff  = (pipe_q[ST_SUM].d2 <= {8'b0, r2_q}) &&
                          (pipe_q[ST_SUM].dot > 43'sd0) && (r2_q != '0);
    pipe_d[ST_AFF].diff = r2_q - pipe_q[ST_SUM].d2[43:0];

    pipe_d[ST_PROD].prod = {38'b0, force_mag} * {16'b0, pipe_q[ST_AFF].dot[37:0]};
    pipe_d[ST_M1].m1     = 32'((pipe_q[ST_PROD].prod + 54'h200000) >> 22);

    if (pipe_q[ST_FADE-1].fade_ge) begin
      pipe_d[ST_FADE].fade16 = V_ONE;
    end else if (pipe_q[ST_FADE-1].fade_le) begin
      pipe_d[ST_FADE].fade16 = V_ZERO;
    end else begin
      pipe_d[ST_FADE].fade16 = fdiv_quo[16:0];
    end

    az = mag25(pipe_q[ST_FADE].oz);
    pipe_d[ST_ZPROD].zprod = {17'b0, az[22:0]} * {23'b0, pipe_q[ST_FADE].fade16};

    pipe_d[ST_VZ].vz   = vz_c;
    pipe_d[ST_VZ].vzsq = {31'b0, vz_c} * {31'b0, vz_c};

    pipe_d[ST_S].s = {pipe_q[ST_VZ].sq_x[45:0], 16'h0000} +
                     {pipe_q[ST_VZ].sq_y[45:0], 16'h0000} + pipe_q[ST_VZ].vzsq;
    pipe_d[ST_Q].q = qdiv_quo[16:0];

    pipe_d[ST_MQ].mq = {17'b0, pipe_q[ST_Q].m1} * {32'b0, pipe_q[ST_Q].q};
    pipe_d[ST_M2].m2 = 32'((pipe_q[ST_MQ].mq + 49'h8000) >> 16);

    pipe_d[ST_N].n = sqrt_root;

    if (pipe_q[ST_U-1].n == '0) begin
      pipe_d[ST_U].ux = V_UNIT_X;
      pipe_d[ST_U].uy = '0;
      pipe_d[ST_U].uz = '0;
    end else begin
      pipe_d[ST_U].ux = udiv_quo_x;
      pipe_d[ST_U].uy = udiv_quo_y;
      pipe_d[ST_U].uz = udiv_quo_z;
    end

    pipe_d[ST_MP].mpx = {25'b0, pipe_q[ST_U].m2} * {32'b0, pipe_q[ST_U].ux};
    pipe_d[ST_MP].mpy = {25'b0, pipe_q[ST_U].m2} * {32'b0, pipe_q[ST_U].uy};
    pipe_d[ST_MP].mpz = {25'b0, pipe_q[ST_U].m2} * {32'b0, pipe_q[ST_U].uz};

    pipe_d[ST_MR].mx    = 33'((pipe_q[ST_MP].mpx + 57'h800000) >> 24);
    pipe_d[ST_MR].my    = 33'((pipe_q[ST_MP].mpy + 57'h800000) >> 24);
    pipe_d[ST_MR].mz    = 33'((pipe_q[ST_MP].mpz + 57'h800000) >> 24);
    pipe_d[ST_MR].neg_x = force_q[15] ^ pipe_q[ST_MP].ox[24];
    pipe_d[ST_MR].neg_y = force_q[15] ^ pipe_q[ST_MP].oy[24];
    pipe_d[ST_MR].neg_z = force_q[15] ^ pipe_q[ST_MP].oz[24];

    if (pipe_q[ST_MR].aff) begin
      pipe_d[ST_VEL].vel.vel_x    = sat32(pipe_q[ST_MR].mx, pipe_q[ST_MR].neg_x);
      pipe_d[ST_VEL].vel.vel_y    = sat32(pipe_q[ST_MR].my, pipe_q[ST_MR].neg_y);
      pipe_d[ST_VEL].vel.vel_z    = sat32(pipe_q[ST_MR].mz, pipe_q[ST_MR].neg_z);
      pipe_d[ST_VEL].vel.affected = 1'b1;
    end else begin
      pipe_d[ST_VEL].vel = '0;
    end

    fdiv_num   = DIV_NW'({pipe_q[ST_OFF].h[21:0], 16'h0000});
    qdiv_num   = DIV_NW'({pipe_q[ST_AFF].diff, 16'h0000});
    udiv_num_x = DIV_NW'({ax[22:0], 32'h0});
    udiv_num_y = DIV_NW'({ay[22:0], 32'h0});
    udiv_num_z = DIV_NW'({pipe_q[ST_N].vz, 24'h0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= int'(PIPE_DEPTH); k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= in_acc;
      for (int k = 2; k <= int'(PIPE_DEPTH); k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  rdv_div u_fdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (fdiv_num),
    .den_i (DIV_DW'(span_q)),
    .quo_o (fdiv_quo)
  );

  rdv_div u_qdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (qdiv_num),
    .den_i (r2_q),
    .quo_o (qdiv_quo)
  );

  rdv_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (pipe_q[ST_S].s),
    .root_o (sqrt_root)
  );

  rdv_div u_udiv_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (udiv_num_x),
    .den_i (DIV_DW'(pipe_q[ST_N].n)),
    .quo_o (udiv_quo_x)
  );

  rdv_div u_udiv_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (udiv_num_y),
    .den_i (DIV_DW'(pipe_q[ST_N].n)),
    .quo_o (udiv_quo_y)
  );

  rdv_div u_udiv_z (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (udiv_num_z),
    .den_i (DIV_DW'(pipe_q[ST_N].n)),
    .quo_o (udiv_quo_z)
  );

  // Output register and skid entry
  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = pipe_q[PIPE_DEPTH].vel;
        out_vld_d = vld_q[PIPE_DEPTH];
      end
    end else if (en && vld_q[PIPE_DEPTH]) begin
      skid_d     = pipe_q[PIPE_DEPTH].vel;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without an output transaction");

  a_skid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && out_stall_i |=> skid_vld_q)
    else $error("skid entry dropped while output stalled");

  a_unaffected_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.affected |->
      (out_q.vel_x == '0) && (out_q.vel_y == '0) && (out_q.vel_z == '0))
    else $error("nonzero velocity on unaffected point");

endmodule

/* rtl/core/rdv_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, DIV_QW stages, advances on en_i.
// ----------------------------------------------------------------------------
module rdv_div
  import rdv_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_DW-1:0] rem_q [DIV_QW];
  logic [DIV_QW-1:0] lo_q  [DIV_QW];
  logic [DIV_QW-1:0] quo_q [DIV_QW];
  logic [DIV_DW-1:0] den_q [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    logic [DIV_DW-1:0] rem_in;
    logic [DIV_QW-1:0] lo_in;
    logic [DIV_QW-1:0] quo_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_DW:0]   trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_in = num_i[DIV_NW-1:DIV_QW];
      assign lo_in  = num_i[DIV_QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, lo_in[DIV_QW-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? DIV_DW'(trial - {1'b0, den_in}) : trial[DIV_DW-1:0];
        lo_q[k]  <= {lo_in[DIV_QW-2:0], 1'b0};
        quo_q[k] <= {quo_in[DIV_QW-2:0], fits};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_QW-1];

endmodule

/* rtl/core/rdv_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, SQ_OW stages, floor result, advances on en_i.
// ----------------------------------------------------------------------------
module rdv_sqrt
  import rdv_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQ_IW-1:0] rad_i,
  output logic [SQ_OW-1:0] root_o
);

  logic [SQ_OW+1:0] rem_q  [SQ_OW];
  logic [SQ_OW-1:0] root_q [SQ_OW];
  logic [SQ_IW-1:0] rad_q  [SQ_OW];

  for (genvar k = 0; k < SQ_OW; k++) begin : g_step
    logic [SQ_OW+1:0] rem_in;
    logic [SQ_OW-1:0] root_in;
    logic [SQ_IW-1:0] rad_in;
    logic [SQ_OW+3:0] part;
    logic [SQ_OW+3:0] trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign part  = {rem_in, rad_in[SQ_IW-1:SQ_IW-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fits  = part >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? (SQ_OW + 2)'(part - trial) : part[SQ_OW+1:0];
        root_q[k] <= {root_in[SQ_OW-2:0], fits};
        rad_q[k]  <= {rad_in[SQ_IW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQ_OW-1];

endmodule
